### hdl/hpvc_pkg.sv
`timescale 1ns / 1ps
package hpvc_pkg;
    localparam int CordicSteps = 16;
    localparam int StepW = 5;
    localparam int AccW = 28;
    localparam int CordW = 36;
    localparam logic signed [15:0] PiQ12 = 16'sd12868;
    localparam logic signed [AccW-1:0] HalfPiQ24 = 28'sd26353589;
    localparam logic [2:0] RegActive = 3'd0;
    localparam logic [2:0] RegMaxLin = 3'd1;
    localparam logic [2:0] RegFast = 3'd2;
    localparam logic [2:0] RegSlow = 3'd3;
    localparam logic [2:0] RegThr = 3'd4;
    localparam logic [2:0] RegStop = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE, S_CORDIC, S_ROUND, S_PREP, S_DIV, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic cordic_step;
        logic round_ang;
        logic div_start;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_cordic;
        logic need_div;
        logic cordic_last;
        logic div_last;
    } t_status;

    function automatic logic signed [AccW-1:0] atan_q24(input logic [StepW-1:0] i);
        logic signed [AccW-1:0] r;
        begin
            case (i)
                5'd0: r = 28'sd13176795;
                5'd1: r = 28'sd7778716;
                5'd2: r = 28'sd4110060;
                5'd3: r = 28'sd2086331;
                5'd4: r = 28'sd1047214;
                5'd5: r = 28'sd524117;
                5'd6: r = 28'sd262123;
                5'd7: r = 28'sd131069;
                default: r = (i < 5'd24) ? (28'sd1 <<< (5'd24 - i)) : 28'sd0;
            endcase
            return r;
        end
    endfunction
endpackage

### hdl/hpvc_if.sv
`timescale 1ns / 1ps
interface hpvc_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] target_right;
    logic signed [15:0] target_up;
    logic signed [15:0] target_ahead;
    logic signed [15:0] target_yaw;
    modport source (output valid, target_right, target_up, target_ahead, target_yaw,
                    input ready);
    modport sink (input valid, target_right, target_up, target_ahead, target_yaw,
                  output ready);
endinterface

interface hpvc_out_if;
    logic valid;
    logic ready;
    logic [15:0] linear_speed;
    logic signed [15:0] angular_rate;
    modport source (output valid, linear_speed, angular_rate, input ready);
    modport sink (input valid, linear_speed, angular_rate, output ready);
endinterface

interface hpvc_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hdl/hpvc_ctrl.sv
`timescale 1ns / 1ps
module hpvc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  hpvc_pkg::t_status i_status,
    output hpvc_pkg::t_cmd    o_cmd
);
    hpvc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hpvc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            hpvc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = hpvc_pkg::S_CORDIC;
                end
            end
            hpvc_pkg::S_CORDIC: begin
                if (i_status.need_cordic) begin
                    o_cmd.cordic_step = 1'b1;
                    if (i_status.cordic_last) n_state = hpvc_pkg::S_ROUND;
                end else begin
                    n_state = hpvc_pkg::S_ROUND;
                end
            end
            hpvc_pkg::S_ROUND: begin
                o_cmd.round_ang = 1'b1;
                n_state = hpvc_pkg::S_PREP;
            end
            hpvc_pkg::S_PREP: begin
                o_cmd.div_start = 1'b1;
                n_state = hpvc_pkg::S_DIV;
            end
            hpvc_pkg::S_DIV: begin
                if (i_status.need_div) begin
                    o_cmd.div_step = 1'b1;
                    if (i_status.div_last) begin
                        o_cmd.finish = 1'b1;
                        n_state = hpvc_pkg::S_OUT;
                    end
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state = hpvc_pkg::S_OUT;
                end
            end
            hpvc_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = hpvc_pkg::S_IDLE;
            end
            default: n_state = hpvc_pkg::S_IDLE;
        endcase
    end
endmodule

### hdl/hpvc_dp.sv
`timescale 1ns / 1ps
module hpvc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hpvc_pkg::t_cmd     i_cmd,
    output hpvc_pkg::t_status  o_status,
    input  logic signed [15:0] i_right,
    input  logic signed [15:0] i_up,
    input  logic signed [15:0] i_ahead,
    input  logic signed [15:0] i_yaw,
    input  logic               i_active,
    input  logic [15:0]        i_max_lin,
    input  logic [14:0]        i_fast,
    input  logic [14:0]        i_slow,
    input  logic [13:0]        i_thr,
    input  logic [14:0]        i_stop,
    output logic [15:0]        o_lin,
    output logic signed [15:0] o_rate
);
    logic signed [hpvc_pkg::CordW-1:0] r_cx, r_cy;
    logic signed [hpvc_pkg::AccW-1:0] r_ang;
    logic [hpvc_pkg::StepW-1:0] r_step;
    logic signed [15:0] r_head, r_last;
    logic r_use_cordic, r_within, r_active;
    logic [31:0] r_num_lin, r_num_rate;
    logic [31:0] r_q_lin, r_q_rate;
    logic [13:0] r_rem_lin, r_rem_rate;
    logic r_prop;
    logic [15:0] r_lin;
    logic signed [15:0] r_rate;

    logic [15:0] ax, az;
    logic near, all_zero, go_cordic;
    logic signed [hpvc_pkg::CordW-1:0] lx, ly, dx, dy;
    logic signed [hpvc_pkg::AccW-1:0] ang_r;
    logic signed [hpvc_pkg::AccW-13:0] q;
    logic signed [15:0] qh;
    logic [15:0] mag;
    logic [14:0] tmp_d;
    logic [14:0] rl_tmp, rr_tmp;
    logic [14:0] nl_rem, nr_rem;
    logic [32:0] fin_lin, fin_rate;

    assign ax = i_right[15] ? 16'(-i_right) : i_right;
    assign az = i_ahead[15] ? 16'(-i_ahead) : i_ahead;
    assign all_zero = (i_right == 0) && (i_up == 0) && (i_ahead == 0);
    assign near = (az < {1'b0, i_stop}) && (ax < {1'b0, i_stop});
    assign go_cordic = i_active && !all_zero && !near && !(i_right == 0 && i_ahead == 0);
    assign lx = hpvc_pkg::CordW'(i_ahead) <<< 16;
    assign ly = hpvc_pkg::CordW'(i_right) <<< 16;
    assign dx = r_cx >>> r_step;
    assign dy = r_cy >>> r_step;
    assign ang_r = r_ang + hpvc_pkg::AccW'(2048);
    assign q = ang_r[hpvc_pkg::AccW-1:12];
    assign qh = (q > (hpvc_pkg::AccW-12)'(hpvc_pkg::PiQ12)) ? hpvc_pkg::PiQ12 :
                (q < -(hpvc_pkg::AccW-12)'(hpvc_pkg::PiQ12)) ? -hpvc_pkg::PiQ12 : 16'(q);
    assign mag = r_head[15] ? 16'(-r_head) : r_head;
    assign tmp_d = 15'(i_thr);
    assign rl_tmp = {r_rem_lin, r_num_lin[31]};
    assign rr_tmp = {r_rem_rate, r_num_rate[31]};
    assign nl_rem = (rl_tmp >= tmp_d) ? rl_tmp - tmp_d : rl_tmp;
    assign nr_rem = (rr_tmp >= tmp_d) ? rr_tmp - tmp_d : rr_tmp;

    assign o_status.need_cordic = r_use_cordic;
    assign o_status.cordic_last = (r_step == 5'(hpvc_pkg::CordicSteps - 1));
    assign o_status.need_div = r_prop;
    assign o_status.div_last = (r_step == 5'd31);

    always_comb begin
        fin_lin = {r_q_lin, (rl_tmp >= tmp_d)};
        fin_rate = {r_q_rate, (rr_tmp >= tmp_d)};
        if (!r_prop) begin
            fin_lin = '0;
            fin_rate = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_use_cordic <= 1'b0;
            r_prop <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_active <= i_active;
                r_within <= near;
                r_step <= '0;
                r_use_cordic <= go_cordic;
                if (i_ahead < 0) begin
                    if (i_right >= 0) begin
                        r_cx <= ly; r_cy <= -lx; r_ang <= hpvc_pkg::HalfPiQ24;
                    end else begin
                        r_cx <= -ly; r_cy <= lx; r_ang <= -hpvc_pkg::HalfPiQ24;
                    end
                end else begin
                    r_cx <= lx; r_cy <= ly; r_ang <= '0;
                end
                if (!i_active || all_zero) begin
                    r_head <= r_last;
                end else if (near) begin
                    r_head <= i_yaw;
                end else begin
                    r_head <= '0;
                end
            end
            if (i_cmd.cordic_step) begin
                r_step <= r_step + 5'd1;
                if (r_cy >= 0) begin
                    r_cx <= r_cx + dy; r_cy <= r_cy - dx;
                    r_ang <= r_ang + hpvc_pkg::atan_q24(r_step);
                end else begin
                    r_cx <= r_cx - dy; r_cy <= r_cy + dx;
                    r_ang <= r_ang - hpvc_pkg::atan_q24(r_step);
                end
            end
            if (i_cmd.round_ang) begin
                r_use_cordic <= 1'b0;
                if (r_use_cordic) r_head <= qh;
            end
            if (i_cmd.div_start) begin
                r_step <= '0;
                r_rem_lin <= '0;
                r_rem_rate <= '0;
                r_q_lin <= '0;
                r_q_rate <= '0;
                r_prop <= r_active && !r_within && i_thr != 0 && mag < {2'b0, i_thr};
                r_num_lin <= 32'(i_max_lin) * 32'({2'b0, i_thr} - mag) + 32'(i_thr >> 1);
                r_num_rate <= 32'(i_slow) * 32'(mag) + 32'(i_thr >> 1);
            end
            if (i_cmd.div_step) begin
                r_step <= r_step + 5'd1;
                r_num_lin <= r_num_lin << 1;
                r_num_rate <= r_num_rate << 1;
                r_rem_lin <= nl_rem[13:0];
                r_rem_rate <= nr_rem[13:0];
                r_q_lin <= {r_q_lin[30:0], (rl_tmp >= tmp_d)};
                r_q_rate <= {r_q_rate[30:0], (rr_tmp >= tmp_d)};
            end
            if (i_cmd.finish) begin
                r_prop <= 1'b0;
                if (!r_active) begin
                    r_lin <= '0;
                    r_rate <= '0;
                end else begin
                    r_last <= r_head;
                    if (r_within) begin
                        r_lin <= '0;
                        r_rate <= r_head[15] ? -16'({1'b0, i_fast}) : 16'({1'b0, i_fast});
                    end else if (r_prop) begin
                        r_lin <= (fin_lin[32:16] != 0) ? 16'hFFFF : fin_lin[15:0];
                        r_rate <= r_head[15] ?
                            -((fin_rate[32:15] != 0) ? 16'h7FFF : 16'(fin_rate[14:0])) :
                            ((fin_rate[32:15] != 0) ? 16'h7FFF : 16'(fin_rate[14:0]));
                    end else begin
                        r_lin <= '0;
                        r_rate <= r_head[15] ? -16'({1'b0, i_slow}) : 16'({1'b0, i_slow});
                    end
                end
            end
        end
    end

    assign o_lin = r_lin;
    assign o_rate = r_rate;
endmodule

### hdl/heading_pursuit_velocity_controller_top.sv
`timescale 1ns / 1ps
// channel   dir  payload
// in        sink target_right, target_up, target_ahead, target_yaw
// out       src  linear_speed, angular_rate
// cfg       sink index (3b), data (16b)
// After the input transaction the block runs 16 CORDIC steps, rounding, divider setup
// and 32 restoring divider steps, then shows the result; it takes no new input before then.
// Without CORDIC or without the divider, that phase runs no steps.
// Reset is synchronous; it resets the state and config registers (threshold to 4096) and clears last heading.
// A stalled result holds the block until taken.
module heading_pursuit_velocity_controller_top (
    input logic i_clk,
    input logic i_rst_n,
    hpvc_in_if.sink   in_ch,
    hpvc_out_if.source out_ch,
    hpvc_cfg_if.sink  cfg_ch
);
    hpvc_pkg::t_cmd cmd;
    hpvc_pkg::t_status status;
    logic r_active;
    logic [15:0] r_max_lin;
    logic [14:0] r_fast, r_slow, r_stop;
    logic [13:0] r_thr;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_max_lin <= '0;
            r_fast <= '0;
            r_slow <= '0;
            r_thr <= 14'd4096;
            r_stop <= '0;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                hpvc_pkg::RegActive: r_active <= cfg_ch.data[0];
                hpvc_pkg::RegMaxLin: r_max_lin <= cfg_ch.data;
                hpvc_pkg::RegFast: r_fast <= cfg_ch.data[14:0];
                hpvc_pkg::RegSlow: r_slow <= cfg_ch.data[14:0];
                hpvc_pkg::RegThr: r_thr <= cfg_ch.data[13:0];
                hpvc_pkg::RegStop: r_stop <= cfg_ch.data[14:0];
                default: ;
            endcase
        end
    end

    hpvc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_status(status), .o_cmd(cmd)
    );

    hpvc_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_status(status),
        .i_right(in_ch.target_right), .i_up(in_ch.target_up),
        .i_ahead(in_ch.target_ahead), .i_yaw(in_ch.target_yaw),
        .i_active(r_active), .i_max_lin(r_max_lin), .i_fast(r_fast),
        .i_slow(r_slow), .i_thr(r_thr), .i_stop(r_stop),
        .o_lin(out_ch.linear_speed), .o_rate(out_ch.angular_rate)
    );
endmodule
